// ----- src/lpc_pkg.sv -----
`default_nettype none
package lpc_pkg;

  // field widths
  localparam int POS_W     = 16;
  localparam int MAX_ITEMS = 1024;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W     = POS_W + $clog2(MAX_ITEMS);
  localparam int STEP_W    = $clog2(POS_W);

  // threshold after reset, unsigned 12.4
  localparam logic [POS_W-1:0] THR_RESET = 16'd16;

  // fault flag bits of the open cluster
  localparam int FLAG_ORDER = 0;
  localparam int FLAG_SAT   = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HAND
  } lpc_state_t;

endpackage
`default_nettype wire

// ----- src/lpc_in_if.sv -----
`default_nettype none
interface lpc_in_if;
  import lpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             last_in_list;

  modport source (output valid, output position, output last_in_list, input ready);
  modport sink   (input valid, input position, input last_in_list, output ready);
endinterface
`default_nettype wire

// ----- src/lpc_out_if.sv -----
`default_nettype none
interface lpc_out_if;
  import lpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] cluster_mean;
  logic             final_cluster;
  logic             order_fault;
  logic             count_saturated;

  modport source (output valid, output cluster_mean, output final_cluster,
                  output order_fault, output count_saturated, input ready);
  modport sink   (input valid, input cluster_mean, input final_cluster,
                  input order_fault, input count_saturated, output ready);
endinterface
`default_nettype wire

// ----- src/lpc_cfg_if.sv -----
`default_nettype none
interface lpc_cfg_if;
  import lpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] thr_value;

  modport source (output valid, output thr_value, input ready);
  modport sink   (input valid, input thr_value, output ready);
endinterface
`default_nettype wire

// ----- src/lpc_serial_div.sv -----
`default_nettype none
module lpc_serial_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lpc_pkg::SUM_W-1:0] dividend,
  input  wire logic [lpc_pkg::CNT_W-1:0] divisor,
  output      logic                      done,
  output      logic [lpc_pkg::POS_W-1:0] quotient
);
  import lpc_pkg::*;

  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [POS_W-1:0]  quo_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    partial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // one quotient bit per cycle: shift in the next dividend bit, trial subtract
  assign partial = {rem_r, quo_r[POS_W-1]};
  assign diff    = partial - {1'b0, div_r};
  assign fits    = (partial >= {1'b0, div_r});
  assign rem_nxt = fits ? diff[CNT_W-1:0] : partial[CNT_W-1:0];

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(POS_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: upper dividend bits are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(dividend[SUM_W-1:POS_W]);
      quo_r <= dividend[POS_W-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[POS_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- src/line_position_clustering_core.sv -----
`default_nettype none
// an item that leaves its cluster open is taken without leaving the idle state
// an item that emits a cluster stops the input while the bit-serial divider forms the mean
// (16 steps, one bit a cycle); the result waits for a free output slot, then input resumes
// an item that closes a cluster and ends the list emits two results, the second after a new division
// reset (rst_n low, synchronous) empties the cluster state and the result register,
// and sets the threshold to 1.0 (16 in 12.4)
module line_position_clustering_core (
  input wire logic clk,
  input wire logic rst_n,
  lpc_in_if.sink   in_item,
  lpc_out_if.source out_item,
  lpc_cfg_if.sink  cfg_wr
);
  import lpc_pkg::*;

  lpc_state_t state_r;
  lpc_state_t state_nxt;

  logic [POS_W-1:0] thr_r;
  logic [POS_W-1:0] anchor_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] prev_r;
  logic             open_r;
  logic [1:0]       flags_r;
  logic             second_r;
  logic [1:0]       job_flags_r;
  logic             job_final_r;

  logic             out_valid_r;
  logic [POS_W-1:0] out_mean_r;
  logic             out_final_r;
  logic             out_order_r;
  logic             out_sat_r;

  logic [POS_W-1:0] pos;
  logic             accept;
  logic             ord;
  logic [POS_W-1:0] anchor_gap;
  logic             close;
  logic [POS_W-1:0] anchor_nxt;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [1:0]       flags_nxt;

  logic             slot_free;
  logic             in_rdy;
  logic             div_start;
  logic             load_out;
  logic             div_done;
  logic [POS_W-1:0] div_quo;
  logic [SUM_W-1:0] div_sum;
  logic [CNT_W-1:0] div_cnt;

  assign pos       = in_item.position;
  assign accept    = in_item.valid && in_rdy;
  assign slot_free = !out_valid_r || out_item.ready;

  // distance to the anchor and order check against the previous position
  assign ord        = open_r && (pos < prev_r);
  assign anchor_gap = (pos >= anchor_r) ? (pos - anchor_r) : (anchor_r - pos);
  assign close      = open_r && (anchor_gap >= thr_r);

  // cluster state after taking in the position
  always_comb begin
    anchor_nxt = anchor_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    flags_nxt  = flags_r;
    if (!open_r || close) begin
      anchor_nxt = pos;
      sum_nxt    = SUM_W'(pos);
      count_nxt  = CNT_W'(1);
      flags_nxt  = {1'b0, ord};
    end else begin
      flags_nxt[FLAG_ORDER] = flags_r[FLAG_ORDER] | ord;
      if (count_r < CNT_W'(MAX_ITEMS)) begin
        sum_nxt   = sum_r + SUM_W'(pos);
        count_nxt = count_r + 1'b1;
      end else begin
        flags_nxt[FLAG_SAT] = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && (close || in_item.last_in_list)) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_HAND;
      ST_HAND: if (slot_free) state_nxt = second_r ? ST_DIV : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_rdy    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_rdy    = 1'b1;
        div_start = in_item.valid && (close || in_item.last_in_list);
      end
      ST_DIV: begin
        in_rdy = 1'b0;
      end
      ST_HAND: begin
        load_out  = slot_free;
        div_start = slot_free && second_r;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // closed cluster comes from the held state, a final one from the updated state
  assign div_sum = (accept && !close) ? sum_nxt : sum_r;
  assign div_cnt = (accept && !close) ? count_nxt : count_r;

  lpc_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_sum),
    .divisor  (div_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr.valid) begin
      thr_r <= cfg_wr.thr_value;
    end
  end

  // cluster state and pending second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r    <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      prev_r      <= '0;
      open_r      <= 1'b0;
      flags_r     <= '0;
      second_r    <= 1'b0;
      job_flags_r <= '0;
      job_final_r <= 1'b0;
    end else if (accept) begin
      prev_r <= pos;
      if (close) begin
        job_flags_r <= flags_r;
        job_final_r <= 1'b0;
        second_r    <= in_item.last_in_list;
      end else if (in_item.last_in_list) begin
        job_flags_r <= flags_nxt;
        job_final_r <= 1'b1;
      end
      if (in_item.last_in_list && !close) begin
        anchor_r <= '0;
        sum_r    <= '0;
        count_r  <= '0;
        flags_r  <= '0;
        open_r   <= 1'b0;
      end else begin
        anchor_r <= anchor_nxt;
        sum_r    <= sum_nxt;
        count_r  <= count_nxt;
        flags_r  <= flags_nxt;
        open_r   <= !in_item.last_in_list;
      end
    end else if (load_out && second_r) begin
      // one-member final cluster follows the closed one
      job_flags_r <= flags_r;
      job_final_r <= 1'b1;
      second_r    <= 1'b0;
      anchor_r    <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      flags_r     <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_r  <= div_quo;
      out_final_r <= job_final_r;
      out_order_r <= job_flags_r[FLAG_ORDER];
      out_sat_r   <= job_flags_r[FLAG_SAT];
    end
  end

  assign in_item.ready            = in_rdy;
  assign cfg_wr.ready             = 1'b1;
  assign out_item.valid           = out_valid_r;
  assign out_item.cluster_mean    = out_mean_r;
  assign out_item.final_cluster   = out_final_r;
  assign out_item.order_fault     = out_order_r;
  assign out_item.count_saturated = out_sat_r;

endmodule
`default_nettype wire

// ----- bench/line_position_clustering_core_test.sv -----
module line_position_clustering_core_test;
  import lpc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 60;
  localparam int PHASE_ITEMS  = 48;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [POS_W-1:0] mean;
    logic             final_cluster;
    logic             order_fault;
    logic             count_saturated;
  } cluster_t;

  // cluster predictor and store of expected clusters
  class cluster_scoreboard;
    logic [POS_W-1:0] threshold;
    logic [POS_W-1:0] anchor;
    logic [POS_W-1:0] prev_pos;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    bit               list_open;
    bit               ord_flag;
    bit               sat_flag;
    cluster_t         expected_q[$];
    int               mismatches;

    function new();
      threshold  = THR_RESET;
      anchor     = '0;
      prev_pos   = '0;
      sum        = '0;
      count      = '0;
      list_open  = 1'b0;
      ord_flag   = 1'b0;
      sat_flag   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [POS_W-1:0] thr);
      threshold = thr;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // queue the mean of the open cluster
    function void push_cluster(bit fin);
      cluster_t c;
      logic [SUM_W-1:0] q;
      q = sum / count;
      c.mean            = q[POS_W-1:0];
      c.final_cluster   = fin;
      c.order_fault     = ord_flag;
      c.count_saturated = sat_flag;
      expected_q.insert(expected_q.size(), c);
    endfunction

    function void open_cluster(logic [POS_W-1:0] pos, bit ord);
      anchor   = pos;
      sum      = SUM_W'(pos);
      count    = CNT_W'(1);
      ord_flag = ord;
      sat_flag = 1'b0;
    endfunction

    // an accepted position item
    function void note_position(logic [POS_W-1:0] pos, logic last);
      logic [POS_W-1:0] anchor_gap;
      bit ord;
      if (!list_open) begin
        open_cluster(pos, 1'b0);
        list_open = 1'b1;
      end else begin
        ord        = (pos < prev_pos);
        anchor_gap = (pos >= anchor) ? pos - anchor : anchor - pos;
        if (anchor_gap < threshold) begin
          ord_flag = ord_flag | ord;
          if (count < CNT_W'(MAX_ITEMS)) begin
            sum   = sum + SUM_W'(pos);
            count = count + 1'b1;
          end else begin
            sat_flag = 1'b1;
          end
        end else begin
          push_cluster(1'b0);
          open_cluster(pos, ord);
        end
      end
      prev_pos = pos;
      if (last) begin
        push_cluster(1'b1);
        list_open = 1'b0;
        anchor    = '0;
        sum       = '0;
        count     = '0;
        ord_flag  = 1'b0;
        sat_flag  = 1'b0;
      end
    endfunction

    // an accepted cluster item against the oldest expectation
    function void check_cluster(cluster_t got);
      cluster_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected cluster: mean %h final %b order %b sat %b",
                   got.mean, got.final_cluster, got.order_fault, got.count_saturated);
        return;
      end
      want = expected_q.pop_front();
      if (got.mean !== want.mean || got.final_cluster !== want.final_cluster ||
          got.order_fault !== want.order_fault ||
          got.count_saturated !== want.count_saturated) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("cluster mismatch: want %h/%b/%b/%b got %h/%b/%b/%b",
                   want.mean, want.final_cluster, want.order_fault, want.count_saturated,
                   got.mean, got.final_cluster, got.order_fault, got.count_saturated);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;
  int   cycle_count = 0;
  int   cur_thr;
  cluster_scoreboard clusters;

  lpc_in_if  in_ch();
  lpc_out_if out_ch();
  lpc_cfg_if cfg_ch();

  line_position_clustering_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_wr   (cfg_ch)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_position_clustering_core_test: FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // check every accepted cluster item
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      clusters.check_cluster({out_ch.cluster_mean, out_ch.final_cluster,
                              out_ch.order_fault, out_ch.count_saturated});
  end

  // offer one position item, with random idle cycles ahead of it
  task automatic send_position(input logic [POS_W-1:0] pos, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.position     <= pos;
    in_ch.last_in_list <= last;
    do @(posedge clk); while (!in_ch.ready);
    clusters.note_position(pos, last);
  endtask

  // hold the input off until every expected cluster has come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (clusters.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [POS_W-1:0] thr);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.thr_value <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    clusters.set_threshold(thr);
    cur_thr = int'(thr);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one list of mostly ascending positions, with some descents and jumps
  task automatic send_random_list(input int len, input int span);
    int p;
    int i;
    p = int'($urandom_range(0, 65535));
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0:             p = p - int'($urandom_range(1, span + 1));
        1:             p = int'($urandom_range(0, 65535));
        2, 3, 4, 5, 6: p = p + int'($urandom_range(span, 2 * span + 64));
        default:       p = p + int'($urandom_range(0, span));
      endcase
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      if (len > 3 && i == len / 2 && $urandom_range(0, 15) == 0)
        wait_drained();
      send_position(p[POS_W-1:0], i == len - 1);
    end
  endtask

  initial begin
    int phase;
    int sent;
    int len;
    int span;
    bit paused;

    clusters           = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.position     = '0;
    in_ch.last_in_list = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.thr_value   = '0;
    gap_pct            = 0;
    stall_pct          = 0;
    cur_thr            = int'(THR_RESET);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-item lists at both ends of the range
    send_position(16'h0000, 1'b1);
    send_position(16'hffff, 1'b1);
    // closing position that is also last gives two clusters
    send_position(16'd100, 1'b0);
    send_position(16'd110, 1'b0);
    send_position(16'd115, 1'b0);
    send_position(16'd200, 1'b0);
    send_position(16'hffff, 1'b1);
    // descending members: joining and opening a new anchor
    send_position(16'd1000, 1'b0);
    send_position(16'd1010, 1'b0);
    send_position(16'd1005, 1'b0);
    send_position(16'd500, 1'b0);
    send_position(16'd505, 1'b1);
    // distance exactly at the threshold closes the cluster
    send_position(16'd300, 1'b0);
    send_position(16'd316, 1'b0);
    send_position(16'd331, 1'b1);
    // distance measured below the anchor
    send_position(16'd400, 1'b0);
    send_position(16'd390, 1'b1);

    // zero threshold: every position is a cluster of its own
    wait_drained();
    write_threshold(16'h0000);
    send_position(16'd7, 1'b0);
    send_position(16'd7, 1'b0);
    send_position(16'd8, 1'b1);

    // widest threshold: only the full span fails to join
    wait_drained();
    write_threshold(16'hffff);
    send_position(16'h0000, 1'b0);
    send_position(16'hffff, 1'b1);
    send_position(16'h0001, 1'b0);
    send_position(16'hffff, 1'b1);

    // random phases under different idling and thresholds
    for (phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  write_threshold(16'hffff); end
        1: begin gap_pct = 61; stall_pct = 0;  write_threshold(16'($urandom_range(1, 3000))); end
        2: begin gap_pct = 0;  stall_pct = 61; write_threshold(16'h0000); end
        3: begin gap_pct = 33; stall_pct = 33; write_threshold(16'($urandom_range(16, 600))); end
        default: begin
          gap_pct = 0; stall_pct = 0; write_threshold(16'($urandom_range(1, 65535)));
        end
      endcase
      span = (cur_thr > 3000) ? 3000 : cur_thr;
      // one list long enough to saturate the member count
      if (phase == 0)
        send_random_list(MAX_ITEMS + 16, 20);
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                          : int'($urandom_range(1, 12));
        send_random_list(len, span);
        sent += len;
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    // drain and finish
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (clusters.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (clusters.mismatches == 0 && clusters.pending() == 0) begin
      $display("line_position_clustering_core_test: PASS");
    end else begin
      $display("line_position_clustering_core_test: FAIL");
    end
    $finish;
  end

endmodule
